// File: src/tedec_pkg.sv
package tedec_pkg;

    typedef enum logic [3:0] {
        ACT_PUT      = 4'd0,
        ACT_HEX      = 4'd1,
        ACT_CLS      = 4'd2,
        ACT_MOVE     = 4'd3,
        ACT_BOLD_ON  = 4'd4,
        ACT_BOLD_OFF = 4'd5,
        ACT_INS_LINE = 4'd6,
        ACT_DEL_LINE = 4'd7,
        ACT_CLR_EOL  = 4'd8,
        ACT_UNKNOWN  = 4'd9
    } t_action;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_DEBUG = 2'd1,
        MODE_TVI   = 2'd2
    } t_mode;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SUB      = 8'h1A;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_R        = 8'h52;
    localparam logic [7:0] CH_T        = 8'h54;

    localparam logic [8:0] COORD_BIAS  = 9'd32;
    localparam int         ESC_SLOTS   = 3;
    localparam logic [1:0] FILL_FULL   = 2'd3;

endpackage

// File: src/terminal_escape_decoder.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_char_in
// out       output     o_out_valid / i_out_stall  o_action, o_char_out,
//                                                 o_first_coord, o_second_coord
// cfg       input      i_cfg_valid / o_cfg_ready  i_terminal_mode
//
// One request per clock unless stalled; its result reaches the output register
// in the cycle after acceptance. Escape state advances in the accepting cycle.
// Requests that produce no action clear output valid but keep the payload.
// The input stalls only while a held result is itself stalled.
// Reset (synchronous, active low) clears mode, escape state and output valid.
module terminal_escape_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_terminal_mode,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tedec_pkg::t_action   o_action,
    output logic [7:0]           o_char_out,
    output logic signed [8:0]    o_first_coord,
    output logic signed [8:0]    o_second_coord
);
    import tedec_pkg::*;

    logic [1:0]        r_mode;
    logic [1:0]        r_pending, n_pending;
    logic [1:0]        r_stage, n_stage;
    logic [1:0]        r_fill, n_fill;
    logic [7:0]        r_bytes [ESC_SLOTS];
    logic [7:0]        n_bytes [ESC_SLOTS];

    logic              r_out_valid;
    t_action           r_action;
    logic [7:0]        r_char;
    logic signed [8:0] r_coord1, r_coord2;

    logic              res_valid;
    t_action           res_action;
    logic [7:0]        res_char;
    logic signed [8:0] res_coord1, res_coord2;
    logic              in_accept;
    logic              first;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign first       = (r_stage == 2'd0);

    always_comb begin
        n_pending  = r_pending;
        n_stage    = r_stage;
        n_fill     = r_fill;
        n_bytes    = r_bytes;
        res_valid  = 1'b1;
        res_action = ACT_PUT;
        res_char   = i_char_in;
        res_coord1 = '0;
        res_coord2 = '0;
        case (r_mode)
            MODE_TVI: begin
                if (r_pending == 2'd0) begin
                    case (i_char_in)
                        CH_NUL: begin
                            res_valid = 1'b0;
                        end
                        CH_SUB: begin
                            res_action = ACT_CLS;
                            res_char   = '0;
                        end
                        CH_ESC: begin
                            res_valid = 1'b0;
                            n_pending = 2'd1;
                            n_stage   = 2'd0;
                            n_fill    = 2'd0;
                        end
                        default: begin
                            res_action = ACT_PUT;
                        end
                    endcase
                end else begin
                    if (r_fill != FILL_FULL) begin
                        n_bytes[r_fill] = i_char_in;
                    end
                    n_fill    = r_fill + 2'd1;
                    n_pending = r_pending - 2'd1;
                    res_char  = '0;
                    if (n_pending != 2'd0) begin
                        res_valid = 1'b0;
                    end else begin
                        case (n_bytes[0])
                            CH_EQUAL: begin
                                if (first) begin
                                    res_valid = 1'b0;
                                    n_pending = 2'd2;
                                end else begin
                                    res_action = ACT_MOVE;
                                    res_coord1 = {1'b0, n_bytes[1]} - COORD_BIAS;
                                    res_coord2 = {1'b0, n_bytes[2]} - COORD_BIAS;
                                end
                            end
                            CH_LPAREN: res_action = ACT_BOLD_ON;
                            CH_RPAREN: res_action = ACT_BOLD_OFF;
                            CH_B: begin
                                if (first) begin
                                    res_valid = 1'b0;
                                    n_pending = 2'd1;
                                end else begin
                                    res_action = ACT_BOLD_ON;
                                end
                            end
                            CH_C: begin
                                if (first) begin
                                    res_valid = 1'b0;
                                    n_pending = 2'd1;
                                end else begin
                                    res_action = ACT_BOLD_OFF;
                                end
                            end
                            CH_E: res_action = ACT_INS_LINE;
                            CH_R: res_action = ACT_DEL_LINE;
                            CH_T: res_action = ACT_CLR_EOL;
                            default: begin
                                res_action = ACT_UNKNOWN;
                                res_char   = n_bytes[0];
                            end
                        endcase
                        if (n_pending != 2'd0) begin
                            n_stage = r_stage + 2'd1;
                        end
                    end
                end
            end
            MODE_DEBUG: begin
                if (i_char_in < CH_SPACE) begin
                    res_action = ACT_HEX;
                end
            end
            default: begin
                res_action = ACT_PUT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PASS;
            r_pending   <= '0;
            r_stage     <= '0;
            r_fill      <= '0;
            r_bytes     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_terminal_mode;
            end
            if (in_accept) begin
                r_pending   <= n_pending;
                r_stage     <= n_stage;
                r_fill      <= n_fill;
                r_bytes     <= n_bytes;
                r_out_valid <= res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_action <= res_action;
            r_char   <= res_char;
            r_coord1 <= res_coord1;
            r_coord2 <= res_coord2;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_char_out     = r_char;
    assign o_first_coord  = r_coord1;
    assign o_second_coord = r_coord2;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tedec_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_action           action;
        logic [7:0]        glyph;
        logic signed [8:0] first_coord;
        logic signed [8:0] second_coord;
    } t_term_action;

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_valid     = 1'b0;
    logic [1:0]        i_terminal_mode = MODE_PASS;
    logic              i_in_valid      = 1'b0;
    logic [7:0]        i_char_in       = 8'd0;
    logic              i_out_stall     = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    t_action           o_action;
    logic [7:0]        o_char_out;
    logic signed [8:0] o_first_coord;
    logic signed [8:0] o_second_coord;

    logic [1:0]   cur_mode    = MODE_PASS;
    logic [1:0]   esc_pending = 2'd0;
    logic [1:0]   esc_stage   = 2'd0;
    logic [1:0]   esc_fill    = 2'd0;
    logic [7:0]   esc_buf [ESC_SLOTS] = '{default: 8'd0};
    t_term_action pending_actions [$];

    int          errors      = 0;
    int          cycle_count = 0;
    int unsigned send_idle   = 30;
    int unsigned recv_idle   = 30;
    int          hold_seq    = 0;
    int          hold_ack    = 0;
    int          hold_left   = 0;

    terminal_escape_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_terminal_mode(i_terminal_mode),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_in      (i_char_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_char_out     (o_char_out),
        .o_first_coord  (o_first_coord),
        .o_second_coord (o_second_coord)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_seq != hold_ack) begin
            hold_ack    <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    function automatic bit predict_action(input logic [7:0] ch, output t_term_action r);
        bit first_pass;
        r = '{ACT_PUT, ch, 9'sd0, 9'sd0};
        if (cur_mode != MODE_TVI) begin
            if (cur_mode == MODE_DEBUG && ch < CH_SPACE) r.action = ACT_HEX;
            return 1'b1;
        end
        if (esc_pending == 2'd0) begin
            case (ch)
                CH_NUL: return 1'b0;
                CH_SUB: begin
                    r.action = ACT_CLS;
                    r.glyph  = 8'd0;
                    return 1'b1;
                end
                CH_ESC: begin
                    esc_pending = 2'd1;
                    esc_stage   = 2'd0;
                    esc_fill    = 2'd0;
                    return 1'b0;
                end
                default: return 1'b1;
            endcase
        end
        if (esc_fill != FILL_FULL) esc_buf[esc_fill] = ch;
        esc_fill++;
        esc_pending--;
        if (esc_pending != 2'd0) return 1'b0;
        first_pass = (esc_stage == 2'd0);
        r.glyph = 8'd0;
        case (esc_buf[0])
            CH_EQUAL: begin
                if (first_pass) begin
                    esc_pending = 2'd2;
                end else begin
                    r.action       = ACT_MOVE;
                    r.first_coord  = {1'b0, esc_buf[1]} - COORD_BIAS;
                    r.second_coord = {1'b0, esc_buf[2]} - COORD_BIAS;
                end
            end
            CH_LPAREN: r.action = ACT_BOLD_ON;
            CH_RPAREN: r.action = ACT_BOLD_OFF;
            CH_B: begin
                if (first_pass) esc_pending = 2'd1;
                else r.action = ACT_BOLD_ON;
            end
            CH_C: begin
                if (first_pass) esc_pending = 2'd1;
                else r.action = ACT_BOLD_OFF;
            end
            CH_E: r.action = ACT_INS_LINE;
            CH_R: r.action = ACT_DEL_LINE;
            CH_T: r.action = ACT_CLR_EOL;
            default: begin
                r.action = ACT_UNKNOWN;
                r.glyph  = esc_buf[0];
            end
        endcase
        if (esc_pending != 2'd0) begin
            esc_stage++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_term_action want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_actions.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected action, expected none, actual %0d char %0d",
                             $time, o_action, o_char_out);
                end else begin
                    want = pending_actions.pop_front();
                    check_field("action", want.action, o_action);
                    check_field("char_out", want.glyph, o_char_out);
                    check_field("first_coord", want.first_coord, o_first_coord);
                    check_field("second_coord", want.second_coord, o_second_coord);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (predict_action(i_char_in, want)) pending_actions.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) cur_mode = i_terminal_mode;
        end
    end

    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= ch;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        drain_results();
        i_cfg_valid     <= 1'b1;
        i_terminal_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_stream(input int count);
        int         sent;
        logic [7:0] cmd;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 70) begin
                case ($urandom_range(8))
                    0: cmd = CH_EQUAL;
                    1: cmd = CH_B;
                    2: cmd = CH_C;
                    3: cmd = CH_LPAREN;
                    4: cmd = CH_RPAREN;
                    5: cmd = CH_E;
                    6: cmd = CH_R;
                    7: cmd = CH_T;
                    default: cmd = 8'($urandom_range(255));
                endcase
                send_char(CH_ESC);
                send_char(cmd);
                sent += 2;
                if (cmd == CH_EQUAL) begin
                    send_char(8'($urandom_range(255)));
                    send_char(8'($urandom_range(255)));
                    sent += 2;
                end else if (cmd == CH_B || cmd == CH_C) begin
                    send_char(8'($urandom_range(255)));
                    sent++;
                end
            end else begin
                case ($urandom_range(9))
                    0: send_char(CH_ESC);
                    1: send_char(CH_NUL);
                    2: send_char(CH_SUB);
                    default: send_char(8'($urandom_range(255)));
                endcase
                sent++;
            end
        end
    endtask

    task automatic test_pass_through();
        send_char(CH_NUL);
        send_char(8'hFF);
    endtask

    task automatic test_debug_marking();
        write_mode(MODE_DEBUG);
        send_char(8'h1F);
        send_char(CH_SPACE);
    endtask

    task automatic test_spare_mode();
        write_mode(MODE_SPARE);
        send_char(8'h1F);
    endtask

    task automatic test_tvi_controls();
        write_mode(MODE_TVI);
        send_char(CH_NUL);
        send_char(CH_SUB);
        send_char(8'h0D);
    endtask

    task automatic test_tvi_escapes();
        send_char(CH_ESC);
        send_char(CH_EQUAL);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_ESC);
        send_char(CH_B);
        send_char(8'h55);
        send_char(CH_ESC);
        send_char(CH_RPAREN);
        send_char(CH_ESC);
        send_char(CH_E);
        send_char(CH_ESC);
        send_char(CH_R);
        send_char(CH_ESC);
        send_char(CH_T);
        send_char(CH_ESC);
        send_char(CH_ESC);
    endtask

    task automatic test_backpressure();
        write_mode(MODE_PASS);
        send_idle = 0;
        hold_seq <= hold_seq + 1;
        repeat (16) send_char(8'($urandom_range(255)));
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 3; seg++) begin
                pick = $urandom_range(9);
                write_mode(pick < 5 ? MODE_TVI : 2'($urandom_range(3)));
                case (phase)
                    0: begin
                        send_idle = 8;
                        recv_idle = 77;
                    end
                    1: begin
                        send_idle = 77;
                        recv_idle = 8;
                    end
                    default: begin
                        send_idle = 0;
                        recv_idle = 0;
                    end
                endcase
                send_random_stream(40);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pass_through();
        test_debug_marking();
        test_spare_mode();
        test_tvi_controls();
        test_tvi_escapes();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/tedec_pkg.sv
src/terminal_escape_decoder.sv
sim/testbench.sv
